[hdl/ple_pkg.sv]
// Shared types and constants for the positional list engine.
package ple_pkg;

	localparam int unsigned FUNC_W = 3;
	localparam int unsigned POS_W  = 7;

	typedef enum logic [FUNC_W-1:0] {
		OP_INSERT   = 3'd0,
		OP_REMOVE   = 3'd1,
		OP_REPLACE  = 3'd2,
		OP_RETRIEVE = 3'd3,
		OP_CLEAR    = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	// per-cycle command broadcast to every cell, already gated by success
	typedef struct packed {
		logic ins;
		logic rem;
		logic wr;
	} cell_cmd_t;

endpackage

[hdl/ple_cell.sv]
// One list slot: holds an entry and shifts with its neighbors.
module ple_cell #(
	parameter int unsigned DATA_WIDTH = 32,
	parameter int unsigned IDX        = 0
) (
	input  logic                      clk,
	input  ple_pkg::cell_cmd_t        cmd,
	input  logic [ple_pkg::POS_W-1:0] pos,
	input  logic [DATA_WIDTH-1:0]     value,
	input  logic [DATA_WIDTH-1:0]     left,
	input  logic [DATA_WIDTH-1:0]     right,
	output logic [DATA_WIDTH-1:0]     slot,
	output logic [DATA_WIDTH-1:0]     rd
);
	import ple_pkg::*;

	localparam logic [31:0] IDX_U = 32'(IDX);

	logic [DATA_WIDTH-1:0] slot_q;
	logic [31:0]           pos_u;
	logic                  at;
	logic                  above;

	assign pos_u = 32'(pos);
	assign at    = (pos_u == IDX_U);
	assign above = (pos_u < IDX_U);

	always_ff @(posedge clk) begin
		if (cmd.ins && (at || above)) begin
			slot_q <= at ? value : left;
		end else if (cmd.rem && (at || above)) begin
			slot_q <= right;
		end else if (cmd.wr && at) begin
			slot_q <= value;
		end
	end

	assign slot = slot_q;
	assign rd   = at ? slot_q : '0;

endmodule

[hdl/ple_ctrl.sv]
// Request decode, entry count and result registers.
module ple_ctrl #(
	parameter int unsigned CAPACITY   = 64,
	parameter int unsigned DATA_WIDTH = 32,
	parameter int unsigned CNT_W      = 7
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [ple_pkg::FUNC_W-1:0] func,
	input  logic [ple_pkg::POS_W-1:0]  position,
	input  logic [DATA_WIDTH-1:0]      rd_all,
	output ple_pkg::cell_cmd_t         cmd,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [DATA_WIDTH-1:0]      data,
	output logic [CNT_W-1:0]           length,
	output logic                       is_full,
	output logic                       is_empty
);
	import ple_pkg::*;

	localparam int unsigned CW = (CNT_W > POS_W) ? CNT_W : POS_W;

	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_nxt;
	logic                  done_q;
	status_t               status_q;
	logic [DATA_WIDTH-1:0] data_q;
	status_t               st;
	cell_cmd_t             cmd_c;
	logic                  rd_en;
	logic                  full;
	logic                  empty;
	logic [CW-1:0]         pos_c;
	logic [CW-1:0]         cnt_c;

	assign full  = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);
	assign pos_c = CW'(position);
	assign cnt_c = CW'(count_q);

	always_comb begin
		st        = ST_OK;
		cmd_c     = '0;
		rd_en     = 1'b0;
		count_nxt = count_q;
		case (func_t'(func))
			OP_INSERT: begin
				if (full) begin
					st = ST_OVERFLOW;
				end else if (pos_c > cnt_c) begin
					st = ST_RANGE;
				end else begin
					cmd_c.ins = 1'b1;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			OP_REMOVE: begin
				if (empty) begin
					st = ST_UNDERFLOW;
				end else if (pos_c >= cnt_c) begin
					st = ST_RANGE;
				end else begin
					cmd_c.rem = 1'b1;
					rd_en     = 1'b1;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			OP_REPLACE: begin
				if (pos_c >= cnt_c) begin
					st = ST_RANGE;
				end else begin
					cmd_c.wr = 1'b1;
				end
			end
			OP_RETRIEVE: begin
				if (pos_c >= cnt_c) begin
					st = ST_RANGE;
				end else begin
					rd_en = 1'b1;
				end
			end
			OP_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
				st = ST_RANGE;
			end
		endcase
	end

	assign cmd = accept ? cmd_c : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= st;
			data_q   <= rd_en ? rd_all : '0;
		end
	end

	assign done     = done_q;
	assign status   = status_q;
	assign data     = data_q;
	assign length   = count_q;
	assign is_full  = full;
	assign is_empty = empty;

endmodule

[hdl/positional_list_engine.sv]
// Top level of the positional list engine: control plus a row of slot cells.
//
//  transfer   ports                                   marked by
//  request    func, position, value                   start high, busy low
//  result     status, data, length, is_full, is_empty  done high, one cycle
//
// Each request is done at its accepting edge: all cells shift or write at that
// edge and the result is on the outputs during the next cycle. busy is
// always low, so a request may be taken every cycle. Reset empties the list;
// slot contents are not cleared. The receiver cannot stall a result.
module positional_list_engine #(
	parameter int unsigned CAPACITY   = 64,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [ple_pkg::FUNC_W-1:0]         func,
	input  logic [ple_pkg::POS_W-1:0]          position,
	input  logic [DATA_WIDTH-1:0]              value,
	output logic                               done,
	output logic [1:0]                         status,
	output logic [DATA_WIDTH-1:0]              data,
	output logic [$clog2(CAPACITY + 1)-1:0]    length,
	output logic                               is_full,
	output logic                               is_empty
);
	import ple_pkg::*;

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	logic                  accept;
	cell_cmd_t             cmd;
	logic [DATA_WIDTH-1:0] slot_w [CAPACITY];
	logic [DATA_WIDTH-1:0] rd_w   [CAPACITY];
	logic [DATA_WIDTH-1:0] rd_all;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	ple_ctrl #(
		.CAPACITY  (CAPACITY),
		.DATA_WIDTH(DATA_WIDTH),
		.CNT_W     (CNT_W)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.func    (func),
		.position(position),
		.rd_all  (rd_all),
		.cmd     (cmd),
		.done    (done),
		.status  (status),
		.data    (data),
		.length  (length),
		.is_full (is_full),
		.is_empty(is_empty)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left;
		logic [DATA_WIDTH-1:0] right;

		if (i == 0) begin : g_first
			assign left = '0;
		end else begin : g_mid_l
			assign left = slot_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right = slot_w[i];
		end else begin : g_mid_r
			assign right = slot_w[i+1];
		end

		ple_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.IDX       (i)
		) u_cell (
			.clk  (clk),
			.cmd  (cmd),
			.pos  (position),
			.value(value),
			.left (left),
			.right(right),
			.slot (slot_w[i]),
			.rd   (rd_w[i])
		);
	end

	// at most one cell drives a nonzero read word
	always_comb begin
		rd_all = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_all = rd_all | rd_w[i];
		end
	end

endmodule

[sim/positional_list_engine_monitor.sv]
// Monitor for the positional list engine: predicts each result and compares it.
`timescale 1ns / 1ps

module positional_list_engine_monitor #(
	parameter int unsigned CAPACITY   = 64,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               busy,
	input  logic [ple_pkg::FUNC_W-1:0]         func,
	input  logic [ple_pkg::POS_W-1:0]          position,
	input  logic [DATA_WIDTH-1:0]              value,
	input  logic                               done,
	input  logic [1:0]                         status,
	input  logic [DATA_WIDTH-1:0]              data,
	input  logic [$clog2(CAPACITY + 1)-1:0]    length,
	input  logic                               is_full,
	input  logic                               is_empty,
	output int                                 fail_count,
	output int                                 pending,
	output int                                 fill_level
);
	import ple_pkg::*;

	localparam int LEN_W = $clog2(CAPACITY + 1);

	typedef struct packed {
		status_t                 st;
		logic [DATA_WIDTH-1:0]   word;
		logic [LEN_W-1:0]        len;
		logic                    full;
		logic                    empty;
	} outcome_t;

	logic [DATA_WIDTH-1:0] cells [CAPACITY];
	int                    count;
	outcome_t              awaited [$];

	function automatic outcome_t apply_request(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p,
			logic [DATA_WIDTH-1:0] v);
		outcome_t o;
		int       k;
		int       pos;
		pos    = p;
		o.st   = ST_OK;
		o.word = '0;
		case (f)
			OP_INSERT: begin
				if (count >= CAPACITY)
					o.st = ST_OVERFLOW;
				else if (pos > count)
					o.st = ST_RANGE;
				else begin
					for (k = count; k > pos; k--)
						cells[k] = cells[k-1];
					cells[pos] = v;
					count++;
				end
			end
			OP_REMOVE: begin
				if (count == 0)
					o.st = ST_UNDERFLOW;
				else if (pos >= count)
					o.st = ST_RANGE;
				else begin
					o.word = cells[pos];
					count--;
					for (k = pos; k < count; k++)
						cells[k] = cells[k+1];
				end
			end
			OP_REPLACE: begin
				if (pos >= count)
					o.st = ST_RANGE;
				else
					cells[pos] = v;
			end
			OP_RETRIEVE: begin
				if (pos >= count)
					o.st = ST_RANGE;
				else
					o.word = cells[pos];
			end
			OP_CLEAR: begin
				count = 0;
			end
			default: begin
				o.st = ST_RANGE;
			end
		endcase
		o.len   = LEN_W'(count);
		o.full  = (count >= CAPACITY);
		o.empty = (count == 0);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		outcome_t want;
		bit       bad;
		if (!arst_n) begin
			count = 0;
			awaited.delete();
			pending    = 0;
			fill_level = 0;
			fail_count = 0;
		end else begin
			// result first: it belongs to a transfer taken at an earlier edge
			if (done) begin
				if (awaited.size() == 0) begin
					$display("%0t: unexpected result: status %0d data %h length %0d",
						$time, status, data, length);
					fail_count++;
				end else begin
					want = awaited.pop_front();
					bad  = 1'b0;
					if (status != want.st) begin
						$display("%0t: status expected %0d, got %0d", $time, want.st, status);
						bad = 1'b1;
					end
					if (data != want.word) begin
						$display("%0t: data expected %h, got %h", $time, want.word, data);
						bad = 1'b1;
					end
					if (length != want.len) begin
						$display("%0t: length expected %0d, got %0d", $time, want.len, length);
						bad = 1'b1;
					end
					if (is_full != want.full) begin
						$display("%0t: is_full expected %0d, got %0d", $time, want.full, is_full);
						bad = 1'b1;
					end
					if (is_empty != want.empty) begin
						$display("%0t: is_empty expected %0d, got %0d", $time, want.empty,
							is_empty);
						bad = 1'b1;
					end
					if (bad)
						fail_count++;
				end
			end
			if (start && !busy)
				awaited.push_back(apply_request(func, position, value));
			pending    = awaited.size();
			fill_level = count;
		end
	end

endmodule

[sim/positional_list_engine_tb.sv]
// Testbench top for the positional list engine: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module positional_list_engine_tb;
	import ple_pkg::*;

	localparam int unsigned CAPACITY   = 64;
	localparam int unsigned DATA_WIDTH = 32;
	localparam int          LEN_W      = $clog2(CAPACITY + 1);
	localparam int          STALL_MAX  = 5000;

	localparam logic [FUNC_W-1:0] FUNC_FIRST_UNUSED = 3'd5;
	localparam logic [FUNC_W-1:0] FUNC_MID_UNUSED   = 3'd6;
	localparam logic [FUNC_W-1:0] FUNC_LAST_UNUSED  = 3'd7;

	localparam int MODE_GROW   = 0;
	localparam int MODE_SHRINK = 1;
	localparam int MODE_CHURN  = 2;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [FUNC_W-1:0]     func;
	logic [POS_W-1:0]      position;
	logic [DATA_WIDTH-1:0] value;
	logic                  done;
	logic [1:0]            status;
	logic [DATA_WIDTH-1:0] data;
	logic [LEN_W-1:0]      length;
	logic                  is_full;
	logic                  is_empty;

	int fails;
	int pending;
	int fill_level;
	int taken = 0;
	int stall_cycles = 0;
	int gap_pct = 0;

	positional_list_engine #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.func     (func),
		.position (position),
		.value    (value),
		.done     (done),
		.status   (status),
		.data     (data),
		.length   (length),
		.is_full  (is_full),
		.is_empty (is_empty)
	);

	positional_list_engine_monitor #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) list_monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.position   (position),
		.value      (value),
		.done       (done),
		.status     (status),
		.data       (data),
		.length     (length),
		.is_full    (is_full),
		.is_empty   (is_empty),
		.fail_count (fails),
		.pending    (pending),
		.fill_level (fill_level)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (start && !busy)
			taken <= taken + 1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_MAX) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic send_req(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
			input logic [DATA_WIDTH-1:0] v);
		int base;
		while ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		base = taken;
		start    <= 1'b1;
		func     <= f;
		position <= p;
		value    <= v;
		do
			@(negedge clk);
		while (taken == base);
	endtask

	task automatic send_random(input int mode);
		int                    r;
		int                    lvl;
		logic [FUNC_W-1:0]     f;
		logic [POS_W-1:0]      p;
		logic [DATA_WIDTH-1:0] v;
		lvl = fill_level;
		r   = $urandom_range(0, 99);
		case (mode)
			MODE_GROW:
				f = (r < 75) ? OP_INSERT : (r < 85) ? OP_RETRIEVE :
					(r < 95) ? OP_REPLACE : OP_REMOVE;
			MODE_SHRINK:
				f = (r < 75) ? OP_REMOVE : (r < 85) ? OP_RETRIEVE :
					(r < 90) ? OP_REPLACE : OP_INSERT;
			default: begin
				if (r < 25)
					f = OP_INSERT;
				else if (r < 50)
					f = OP_REMOVE;
				else if (r < 70)
					f = OP_REPLACE;
				else if (r < 94)
					f = OP_RETRIEVE;
				else if (r < 97)
					f = OP_CLEAR;
				else
					f = FUNC_W'($urandom_range(FUNC_FIRST_UNUSED, FUNC_LAST_UNUSED));
			end
		endcase
		r = $urandom_range(0, 9);
		if (r < 8) begin
			if (f == OP_INSERT)
				p = POS_W'($urandom_range(0, lvl));
			else
				p = (lvl > 0) ? POS_W'($urandom_range(0, lvl - 1)) : '0;
		end else if (r == 8)
			p = POS_W'(lvl);
		else
			p = POS_W'($urandom_range(0, 127));
		case ($urandom_range(0, 9))
			0:       v = '0;
			1:       v = '1;
			2:       v = DATA_WIDTH'(1) << $urandom_range(0, DATA_WIDTH - 1);
			default: v = DATA_WIDTH'($urandom);
		endcase
		send_req(f, p, v);
	endtask

	task automatic run_phase(input int items);
		int left;
		int run;
		int mode;
		left = items;
		while (left > 0) begin
			mode = $urandom_range(MODE_GROW, MODE_CHURN);
			run  = (mode == MODE_CHURN) ? $urandom_range(20, 80) : $urandom_range(40, 150);
			if (run > left)
				run = left;
			repeat (run) send_random(mode);
			left -= run;
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin
		arst_n   = 1'b0;
		start    = 1'b0;
		func     = OP_INSERT;
		position = '0;
		value    = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty list, shifts at both ends and middle, bad positions, spare codes
		send_req(OP_RETRIEVE, 7'd0, '0);
		send_req(OP_REMOVE, 7'd0, '0);
		send_req(OP_REMOVE, 7'd127, '1);
		send_req(OP_INSERT, 7'd1, 32'h1111_1111);
		send_req(OP_INSERT, 7'd0, 32'h0000_0000);
		send_req(OP_INSERT, 7'd1, 32'hFFFF_FFFF);
		send_req(OP_INSERT, 7'd0, 32'hA5A5_A5A5);
		send_req(OP_INSERT, 7'd1, 32'h5A5A_5A5A);
		send_req(OP_RETRIEVE, 7'd3, '0);
		send_req(OP_RETRIEVE, 7'd127, '0);
		send_req(OP_REPLACE, 7'd2, 32'h1234_5678);
		send_req(OP_REPLACE, 7'd4, 32'hDEAD_BEEF);
		send_req(OP_RETRIEVE, 7'd2, '0);
		send_req(OP_REMOVE, 7'd1, '0);
		send_req(OP_REMOVE, 7'd3, '0);
		send_req(FUNC_FIRST_UNUSED, 7'd127, '1);
		send_req(FUNC_MID_UNUSED, 7'd0, '1);
		send_req(FUNC_LAST_UNUSED, 7'd127, '1);
		send_req(OP_INSERT, 7'd127, '1);
		send_req(OP_RETRIEVE, 7'd0, '0);
		send_req(OP_CLEAR, 7'd127, '1);
		send_req(OP_RETRIEVE, 7'd0, '0);
		send_req(OP_INSERT, 7'd0, 32'h0000_0001);

		gap_pct = 0;
		run_phase(700);
		drain();
		gap_pct = 82;
		run_phase(600);
		gap_pct = 8;
		run_phase(700);
		drain();
		repeat (4) @(posedge clk);

		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
